[hw/rtl/hkrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrb_pkg
// Types, constants and the character map for the keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

   localparam int unsigned BITMAP_BYTES  = 29;
   localparam logic [4:0]  MOD_INDEX     = 5'd28;
   localparam int unsigned SLOT_COUNT    = 6;
   localparam logic [2:0]  SLOT_LIMIT    = 3'd6;
   localparam logic [7:0]  SHIFT_BIT     = 8'h02;
   localparam logic [7:0]  OVERFLOW_CODE = 8'h01;
   localparam logic [7:0]  UNKNOWN_CODE  = 8'h55;
   localparam logic [7:0]  SPACE_CODE    = 8'h2c;
   localparam logic [7:0]  ENTER_CODE    = 8'h28;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [7:0] code;
      logic [7:0] shift;
   } char_map_type;

   function automatic char_map_type map_char(input logic [7:0] ch);
      char_map_type m;
      m.shift = 8'h00;
      m.code  = UNKNOWN_CODE;
      if (ch >= 8'h61 && ch <= 8'h7a) begin
         m.code = ch - 8'h61 + 8'h04;
      end else if (ch >= 8'h41 && ch <= 8'h5a) begin
         m.code  = ch - 8'h41 + 8'h04;
         m.shift = SHIFT_BIT;
      end else if (ch >= 8'h31 && ch <= 8'h39) begin
         m.code = ch - 8'h31 + 8'h1e;
      end else begin
         case (ch)
            8'h28: begin m.code = 8'h26; m.shift = SHIFT_BIT; end
            8'h29: begin m.code = 8'h27; m.shift = SHIFT_BIT; end
            8'h30: m.code = 8'h27;
            8'h20: m.code = SPACE_CODE;
            8'h5f: begin m.code = 8'h2d; m.shift = SHIFT_BIT; end
            8'h2d: m.code = 8'h2d;
            8'h2b: begin m.code = 8'h2e; m.shift = SHIFT_BIT; end
            8'h3d: m.code = 8'h2e;
            8'h5b: m.code = 8'h2f;
            8'h5d: m.code = 8'h30;
            8'h3b: m.code = 8'h33;
            8'h2c: m.code = 8'h36;
            8'h2e: m.code = 8'h37;
            8'h2f: m.code = 8'h38;
            8'h0a: m.code = ENTER_CODE;
            default: m.code = UNKNOWN_CODE;
         endcase
      end
      return m;
   endfunction

endpackage

[hw/rtl/hid_keyboard_report_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_unit
// Keeps the pressed-key bitmap and builds a six-key boot keyboard report.
// ----------------------------------------------------------------------------
// a request is accepted in ST_IDLE; the 29-byte key bitmap then rotates through
//   the scan head in ST_SCAN, one byte per cycle, and ST_FINISH loads the response
//   into the output register; req_stall stays high until then, one request at a time
// the output register lets the next scan start while a response is stalled
// reset (synchronous) clears the bitmap: no key pressed, no response pending
module hid_keyboard_report_builder_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hkrb_pkg::byte_type    req_key_code,
   input  logic                  req_key_release,
   input  logic                  req_char_valid,
   input  hkrb_pkg::byte_type    req_char_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hkrb_pkg::byte_type    rsp_modifier_byte,
   output hkrb_pkg::byte_type    rsp_slot_one,
   output hkrb_pkg::byte_type    rsp_slot_two,
   output hkrb_pkg::byte_type    rsp_slot_three,
   output hkrb_pkg::byte_type    rsp_slot_four,
   output hkrb_pkg::byte_type    rsp_slot_five,
   output hkrb_pkg::byte_type    rsp_slot_six
);
   import hkrb_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]   state_ff;
   logic [4:0]   cnt_ff;
   logic [7:0]   code_ff;
   logic         release_ff;
   logic [7:0]   bitmap_ff [BITMAP_BYTES];
   logic [7:0]   slot_ff   [SLOT_COUNT];
   logic [7:0]   slot_in   [SLOT_COUNT];
   logic [2:0]   used_ff;
   logic [2:0]   used_in;
   logic         ovf_ff;
   logic         ovf_in;
   logic [7:0]   mod_ff;
   logic [7:0]   head_in;
   logic [7:0]   mask;
   logic         hit;
   logic         accept;
   logic         rsp_valid_ff;
   logic [7:0]   rsp_mod_ff;
   logic [7:0]   rsp_slot_ff [SLOT_COUNT];
   char_map_type cmap;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cmap      = map_char(req_char_code);

   // bitmap head update and byte scan into the slots
   always_comb begin
      hit     = (code_ff != 8'h00) && (code_ff[7:3] == cnt_ff);
      mask    = 8'h01 << code_ff[2:0];
      head_in = bitmap_ff[0];
      if (hit) begin
         head_in = release_ff ? (bitmap_ff[0] & ~mask) : (bitmap_ff[0] | mask);
      end
      slot_in = slot_ff;
      used_in = used_ff;
      ovf_in  = ovf_ff;
      if (cnt_ff != MOD_INDEX) begin
         for (int b = 0; b < 8; b++) begin
            if (head_in[b] && !ovf_in) begin
               if (used_in < SLOT_LIMIT) begin
                  slot_in[used_in] = {cnt_ff, 3'(b)};
                  used_in          = used_in + 3'd1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 5'd0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= 3'd0;
         ovf_ff       <= 1'b0;
         for (int i = 0; i < BITMAP_BYTES; i++) begin
            bitmap_ff[i] <= 8'h00;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff   <= ST_SCAN;
                  cnt_ff     <= 5'd0;
                  code_ff    <= req_key_code;
                  release_ff <= req_key_release;
                  ovf_ff     <= 1'b0;
                  for (int s = 1; s < SLOT_COUNT; s++) begin
                     slot_ff[s] <= 8'h00;
                  end
                  if (req_char_valid) begin
                     slot_ff[0] <= cmap.code;
                     mod_ff     <= cmap.shift;
                     used_ff    <= 3'd1;
                  end else begin
                     slot_ff[0] <= 8'h00;
                     mod_ff     <= 8'h00;
                     used_ff    <= 3'd0;
                  end
               end
            end
            ST_SCAN: begin
               // rotate the bitmap so every byte passes the head once
               for (int i = 0; i < BITMAP_BYTES - 1; i++) begin
                  bitmap_ff[i] <= bitmap_ff[i + 1];
               end
               bitmap_ff[BITMAP_BYTES - 1] <= head_in;
               slot_ff <= slot_in;
               used_ff <= used_in;
               ovf_ff  <= ovf_in;
               if (cnt_ff == MOD_INDEX) begin
                  mod_ff   <= mod_ff | head_in;
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff   <= cnt_ff + 5'd1;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_mod_ff   <= mod_ff;
                  for (int s = 0; s < SLOT_COUNT; s++) begin
                     rsp_slot_ff[s] <= ovf_ff ? OVERFLOW_CODE : slot_ff[s];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_modifier_byte = rsp_mod_ff;
   assign rsp_slot_one      = rsp_slot_ff[0];
   assign rsp_slot_two      = rsp_slot_ff[1];
   assign rsp_slot_three    = rsp_slot_ff[2];
   assign rsp_slot_four     = rsp_slot_ff[3];
   assign rsp_slot_five     = rsp_slot_ff[4];
   assign rsp_slot_six      = rsp_slot_ff[5];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= MOD_INDEX))
      else $error("scan counter beyond bitmap");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOT_LIMIT)
      else $error("slot fill count beyond six");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (used_ff == SLOT_LIMIT))
      else $error("overflow flagged with free slots");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN && cnt_ff == 5'd0))
      else $error("accepted request did not start a scan");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish");

endmodule
